/* design/ddm_pkg.sv */
package ddm_pkg;

    localparam int FRACTION_BITS       = 14;
    localparam int ANGLE_FRACTION_BITS = 7;

    localparam int UNIT_ONE = 1 << FRACTION_BITS;
    localparam int DEG_UNIT = 1 << ANGLE_FRACTION_BITS;

    localparam logic signed [15:0] ONE_Q   = 16'(UNIT_ONE);
    localparam logic signed [15:0] DEG_45  = 16'(45 * DEG_UNIT);
    localparam logic signed [15:0] DEG_90  = 16'(90 * DEG_UNIT);
    localparam logic signed [15:0] DEG_135 = 16'(135 * DEG_UNIT);
    localparam logic signed [15:0] DEG_180 = 16'(180 * DEG_UNIT);

    // Divider geometry: numerator magnitude, divisor and quotient widths.
    localparam int NUM_W  = 28;
    localparam int DEN_W  = 15;
    localparam int QUOT_W = 15;

    typedef enum logic [1:0] {
        KIND_SIGNED   = 2'd0,
        KIND_UNSIGNED = 2'd1,
        KIND_POWER    = 2'd2,
        KIND_UNUSED   = 2'd3
    } t_kind;

    // Sideband carried alongside the divider.
    typedef struct packed {
        logic signed [15:0] fixed_val;  // field that does not take the quotient
        logic signed [15:0] base;       // offset added to the signed quotient
        logic               q_second;   // quotient goes to second result
        logic               neg;        // negate the quotient magnitude
        logic               clamp;      // clamp the quotient field to +-1.0
    } t_side;

endpackage

/* design/ddm_div.sv */
module ddm_div
    import ddm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  t_side             i_side,
    output logic              o_valid,
    output logic [QUOT_W-1:0] o_quot,
    output t_side             o_side
);

    // One quotient bit per stage, MSB first.
    logic              w_valid [0:QUOT_W-1];
    logic [NUM_W-1:0]  w_rem   [0:QUOT_W-1];
    logic [DEN_W-1:0]  w_den   [0:QUOT_W-1];
    logic [QUOT_W-1:0] w_quot  [0:QUOT_W-1];
    t_side             w_side  [0:QUOT_W-1];

    logic              r_valid [0:QUOT_W-1];
    logic [NUM_W-1:0]  r_rem   [0:QUOT_W-1];
    logic [DEN_W-1:0]  r_den   [0:QUOT_W-1];
    logic [QUOT_W-1:0] r_quot  [0:QUOT_W-1];
    t_side             r_side  [0:QUOT_W-1];

    genvar k;
    generate
        for (k = 0; k < QUOT_W; k++) begin : g_stage
            logic [NUM_W+1:0] trial;
            logic             ge;

            if (k == 0) begin : g_first
                assign w_valid[k] = i_valid;
                assign w_rem[k]   = i_num;
                assign w_den[k]   = i_den;
                assign w_quot[k]  = '0;
                assign w_side[k]  = i_side;
            end else begin : g_next
                assign w_valid[k] = r_valid[k-1];
                assign w_rem[k]   = r_rem[k-1];
                assign w_den[k]   = r_den[k-1];
                assign w_quot[k]  = r_quot[k-1];
                assign w_side[k]  = r_side[k-1];
            end

            assign trial = (NUM_W+2)'(w_den[k]) << (QUOT_W - 1 - k);
            assign ge    = {2'b00, w_rem[k]} >= trial;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= w_valid[k];
                end
                if (i_en) begin
                    r_rem[k]  <= ge ? NUM_W'({2'b00, w_rem[k]} - trial) : w_rem[k];
                    r_den[k]  <= w_den[k];
                    r_quot[k] <= {w_quot[k][QUOT_W-2:0], ge};
                    r_side[k] <= w_side[k];
                end
            end
        end
    endgenerate

    assign o_valid = r_valid[QUOT_W-1];
    assign o_quot  = r_quot[QUOT_W-1];
    assign o_side  = r_side[QUOT_W-1];

endmodule

/* design/differential_drive_mixer.sv */
// Pipeline from input transfer to result: clamp, decode, multiply, round,
// 15 divider stages, output register.
// Throughput: one transfer per cycle; the 15-stage restoring divider is
// fully pipelined, so the whole pipe only holds when the output is stalled.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module differential_drive_mixer
    import ddm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_source_kind,
    input  logic [1:0]         i_target_kind,
    input  logic signed [15:0] i_first_value,
    input  logic signed [15:0] i_second_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_first_result,
    output logic signed [15:0] o_second_result
);

    // Global advance: every stage moves unless the output holds a stalled result.
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    // ---------------- Stage 1: clamp values to the source ranges ----------------
    logic signed [15:0] n_a, n_b;
    logic               r1_valid;
    logic signed [15:0] r1_a, r1_b;
    t_kind              r1_src, r1_dst;

    always_comb begin
        n_a = i_first_value;
        n_b = i_second_value;
        case (t_kind'(i_source_kind))
            KIND_SIGNED: begin
                if (n_a < -ONE_Q) n_a = -ONE_Q;
                if (n_a > ONE_Q) n_a = ONE_Q;
                if (n_b < -DEG_90) n_b = -DEG_90;
                if (n_b > DEG_90) n_b = DEG_90;
            end
            KIND_UNSIGNED: begin
                if (n_a < 0) n_a = '0;
                if (n_a > ONE_Q) n_a = ONE_Q;
                if (n_b < -DEG_180) n_b = -DEG_180;
                if (n_b > DEG_180) n_b = DEG_180;
            end
            KIND_POWER: begin
                if (n_a < -ONE_Q) n_a = -ONE_Q;
                if (n_a > ONE_Q) n_a = ONE_Q;
                if (n_b < -ONE_Q) n_b = -ONE_Q;
                if (n_b > ONE_Q) n_b = ONE_Q;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid <= i_valid;
        end
        if (w_en) begin
            r1_a   <= n_a;
            r1_b   <= n_b;
            r1_src <= t_kind'(i_source_kind);
            r1_dst <= t_kind'(i_target_kind);
        end
    end

    // ---------------- Stage 2: decode the conversion ----------------
    // Each case becomes: one field passed as is, the other base +/- q where
    // q = round(|m1*m2| / den). Cases without division use m1 = 0, den = 1.
    logic signed [15:0] n_m1, n_m2;
    logic [DEN_W-1:0]   n_den;
    t_side              n_side;
    logic signed [15:0] w_la, w_lb;
    logic               w_uo;

    assign w_la = r1_a < 0 ? -r1_a : r1_a;
    assign w_lb = r1_b < 0 ? -r1_b : r1_b;
    assign w_uo = (r1_dst == KIND_UNSIGNED);

    always_comb begin
        n_m1   = '0;
        n_m2   = '0;
        n_den  = DEN_W'(1);
        n_side = '{fixed_val: '0, base: '0, q_second: 1'b1, neg: 1'b0, clamp: 1'b0};

        if (r1_src == KIND_UNUSED || r1_dst == KIND_UNUSED) begin
            // leave both fields zero
        end else if (r1_src == r1_dst) begin
            n_side.fixed_val = r1_a;
            n_side.base      = r1_b;
        end else if (r1_src == KIND_POWER) begin
            // powers into speed/heading: faster motor sets the speed
            n_m2 = DEG_45;
            if (w_la >= w_lb) begin
                n_side.fixed_val = w_uo ? w_la : r1_a;
                n_m1  = r1_b;
                n_den = DEN_W'(w_la);
                if (r1_a > 0) begin
                    n_side.base = DEG_45;
                    n_side.neg  = 1'b1;
                end else if (r1_a == 0) begin
                    n_m1  = '0;
                    n_den = DEN_W'(1);
                end else begin
                    n_side.base = w_uo ? DEG_135 : DEG_45;
                    n_side.neg  = 1'b1;   // divisor is negative
                end
            end else begin
                n_side.fixed_val = w_uo ? w_lb : r1_b;
                n_m1  = r1_a;
                n_den = DEN_W'(w_lb);
                if (r1_b >= 0) begin
                    n_side.base = -DEG_45;
                end else begin
                    // subtract a quotient whose divisor is negative
                    n_side.base = w_uo ? -DEG_135 : -DEG_45;
                end
            end
        end else if (r1_dst == KIND_SIGNED) begin
            // unsigned speed into signed: fold the rear half-plane
            if (r1_b < -DEG_90) begin
                n_side.fixed_val = -r1_a;
                n_side.base      = -DEG_180 - r1_b;
            end else if (r1_b > DEG_90) begin
                n_side.fixed_val = -r1_a;
                n_side.base      = DEG_180 - r1_b;
            end else begin
                n_side.fixed_val = r1_a;
                n_side.base      = r1_b;
            end
        end else if (r1_dst == KIND_UNSIGNED) begin
            // signed speed into unsigned: reverse speed flips the heading
            if (r1_a < 0) begin
                n_side.fixed_val = -r1_a;
                n_side.base      = r1_b < 0 ? -r1_b - DEG_180 : DEG_180 - r1_b;
            end else begin
                n_side.fixed_val = r1_a;
                n_side.base      = r1_b;
            end
        end else begin
            // speed/heading into powers: 45 degree linear mix
            n_side.clamp = 1'b1;
            n_m1  = r1_a;
            n_den = DEN_W'(DEG_45);
            if (r1_b >= 0 && (r1_src == KIND_SIGNED || r1_b < DEG_90)) begin
                n_side.fixed_val = r1_a;
                n_m2 = DEG_45 - r1_b;
            end else if (r1_b >= DEG_90) begin
                n_side.q_second  = 1'b0;
                n_side.fixed_val = -r1_a;
                n_m2 = DEG_135 - r1_b;
            end else if (r1_b < -DEG_90 && r1_src == KIND_UNSIGNED) begin
                n_side.fixed_val = -r1_a;
                n_m2 = DEG_135 + r1_b;
            end else begin
                n_side.q_second  = 1'b0;
                n_side.fixed_val = r1_a;
                n_m2 = DEG_45 + r1_b;
            end
        end
    end

    logic               r2_valid;
    logic signed [15:0] r2_m1, r2_m2;
    logic [DEN_W-1:0]   r2_den;
    t_side              r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_en) begin
            r2_valid <= r1_valid;
        end
        if (w_en) begin
            r2_m1   <= n_m1;
            r2_m2   <= n_m2;
            r2_den  <= n_den;
            r2_side <= n_side;
        end
    end

    // ---------------- Stage 3: multiply ----------------
    logic               r3_valid;
    logic signed [31:0] r3_prod;
    logic [DEN_W-1:0]   r3_den;
    t_side              r3_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (w_en) begin
            r3_valid <= r2_valid;
        end
        if (w_en) begin
            r3_prod <= r2_m1 * r2_m2;
            r3_den  <= r2_den;
            r3_side <= r2_side;
        end
    end

    // ---------------- Stage 4: magnitude plus half divisor ----------------
    logic [31:0] w_pmag;
    t_side       n4_side;

    assign w_pmag = r3_prod < 0 ? 32'(-r3_prod) : 32'(r3_prod);

    always_comb begin
        n4_side     = r3_side;
        n4_side.neg = r3_side.neg ^ (r3_prod < 0);
    end

    logic             r4_valid;
    logic [NUM_W-1:0] r4_num;
    logic [DEN_W-1:0] r4_den;
    t_side            r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (w_en) begin
            r4_valid <= r3_valid;
        end
        if (w_en) begin
            r4_num  <= w_pmag[NUM_W-1:0] + NUM_W'(r3_den >> 1);
            r4_den  <= r3_den;
            r4_side <= n4_side;
        end
    end

    // ---------------- Divider ----------------
    logic              w_dv_valid;
    logic [QUOT_W-1:0] w_quot;
    t_side             w_dv_side;

    ddm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_valid),
        .i_num   (r4_num),
        .i_den   (r4_den),
        .i_side  (r4_side),
        .o_valid (w_dv_valid),
        .o_quot  (w_quot),
        .o_side  (w_dv_side)
    );

    // ---------------- Output stage: apply sign, offset, clamp, route ----------------
    logic signed [17:0] w_q, w_v;
    logic signed [15:0] w_res;

    assign w_q = w_dv_side.neg ? -18'(w_quot) : 18'(w_quot);
    assign w_v = 18'(w_dv_side.base) + w_q;

    always_comb begin
        w_res = w_v[15:0];
        if (w_dv_side.clamp) begin
            if (w_v < 18'(-ONE_Q)) w_res = -ONE_Q;
            else if (w_v > 18'(ONE_Q)) w_res = ONE_Q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_dv_valid;
        end
        if (w_en) begin
            o_first_result  <= w_dv_side.q_second ? w_dv_side.fixed_val : w_res;
            o_second_result <= w_dv_side.q_second ? w_res : w_dv_side.fixed_val;
        end
    end

`ifndef ASSERT_OFF
    a_stall_follows_output: assert property (@(posedge i_clk)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not match output hold");

    a_first_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_result >= -ONE_Q && o_first_result <= ONE_Q))
        else $error("first result out of range");

    a_second_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_result >= -DEG_180 && o_second_result <= DEG_180))
        else $error("second result out of range");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");
`endif

endmodule
